FILE: rtl/core/windowed_average_range_check_unit_macros.svh
// Assertion macros for the windowed average range check unit
`ifndef WINDOWED_AVERAGE_RANGE_CHECK_UNIT_MACROS_SVH
`define WINDOWED_AVERAGE_RANGE_CHECK_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define WAVRC_ASSERT_IMM(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define WAVRC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/wavrc_pkg.sv
// Shared types and constants for the windowed average range check unit
package wavrc_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int STAMP_W    = 32;
    localparam int LIMIT_W    = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int WINDOW_DEF = 5;

    localparam logic [LIMIT_W-1:0] LOW_RESET  = 16'd250;
    localparam logic [LIMIT_W-1:0] HIGH_RESET = 16'd1000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOW  = 2'd0,
        CFG_HIGH = 2'd1
    } t_cfg_idx;

    // Operation of the shared add/subtract unit
    typedef enum logic [1:0] {
        OP_HOLD = 2'd0,
        OP_CLR  = 2'd1,
        OP_ACC  = 2'd2,
        OP_DIV  = 2'd3
    } t_op;

    typedef struct packed {
        t_op                 op;
        logic [SAMPLE_W-1:0] data;
    } t_arith_ctl;

endpackage

FILE: rtl/core/wavrc_if.sv
// Valid/ready stream interfaces for the input and result channels
interface wavrc_in_if import wavrc_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;
    logic [STAMP_W-1:0]  stamp;

    modport source (output valid, output sample, output stamp, input ready);
    modport sink   (input valid, input sample, input stamp, output ready);
endinterface

interface wavrc_out_if import wavrc_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] mean;
    logic                anomaly;
    logic [STAMP_W-1:0]  stamp_out;

    modport source (output valid, output mean, output anomaly, output stamp_out, input ready);
    modport sink   (input valid, input mean, input anomaly, input stamp_out, output ready);
endinterface

FILE: rtl/core/windowed_average_range_check_unit.sv
// Top level: windowed average with range alarm, sequencer around a shared adder
//
//   channel  | dir | handshake      | payload
//   i_in     | in  | valid / ready  | sample[15:0], stamp[31:0]
//   o_out    | out | valid / ready  | mean[15:0], anomaly, stamp_out[31:0]
//   i_cfg_*  | in  | write enable   | idx[1:0] (0 low, 1 high), data[15:0]
//
// An item is stored, then the valid entries are summed through the shared
// adder (the ring read is registered, so the first sum step only fetches),
// then SW divide steps run (SW = 19 for WINDOW = 5), and finally the result
// register is loaded. i_in.ready is high only while the sequencer is idle.
// A result waiting in the output register does not block the next
// transaction; only the load step waits for it. Reset is synchronous; the
// sample ring needs no clearing.
`include "windowed_average_range_check_unit_macros.svh"

module windowed_average_range_check_unit
    import wavrc_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    wavrc_in_if.sink              i_in,
    wavrc_out_if.source           o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int IW  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int NW  = $clog2(WINDOW + 1);
    localparam int SW  = $clog2(WINDOW * ((1 << SAMPLE_W) - 1) + 1);
    localparam int DCW = $clog2(SW);
    localparam int CW  = (DCW > NW) ? DCW : NW;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SUM  = 4'b0010,
        S_DIV  = 4'b0100,
        S_LOAD = 4'b1000
    } t_state;

    t_state              r_state, n_state;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic [IW-1:0]       r_wp;
    logic                r_filled;
    logic [NW-1:0]       r_n;
    logic [STAMP_W-1:0]  r_stamp;
    logic [LIMIT_W-1:0]  r_low;
    logic [LIMIT_W-1:0]  r_high;
    logic                r_out_valid;
    logic [SAMPLE_W-1:0] r_out_mean;
    logic                r_out_anom;
    logic [STAMP_W-1:0]  r_out_stamp;

    logic                w_in_acc;
    logic                w_load;
    logic                w_wrap;
    logic [SAMPLE_W-1:0] w_rdata;
    logic [SW-1:0]       w_quot;
    logic [NW-1:0]       w_rem;
    logic [SAMPLE_W-1:0] w_mean;
    logic                w_anom;
    t_arith_ctl          w_ctl;

    assign i_in.ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_wrap     = (r_wp == IW'(WINDOW - 1));
    assign w_load     = (r_state == S_LOAD) && (!r_out_valid || o_out.ready);

    wavrc_window #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WINDOW),
        .IW    (IW)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (w_in_acc),
        .i_waddr (r_wp),
        .i_wdata (i_in.sample),
        .i_raddr (r_cnt[IW-1:0]),
        .o_rdata (w_rdata)
    );

    // Read data is registered: entry k is added at count k + 1
    always_comb begin
        w_ctl.data = w_rdata;
        if (w_in_acc) begin
            w_ctl.op = OP_CLR;
        end else if ((r_state == S_SUM) && (r_cnt != '0)) begin
            w_ctl.op = OP_ACC;
        end else if (r_state == S_DIV) begin
            w_ctl.op = OP_DIV;
        end else begin
            w_ctl.op = OP_HOLD;
        end
    end

    wavrc_arith #(
        .NW (NW),
        .SW (SW)
    ) u_arith (
        .i_clk     (i_clk),
        .i_ctl     (w_ctl),
        .i_divisor (r_n),
        .o_quot    (w_quot),
        .o_rem     (w_rem)
    );

    // mean < low, or exact mean > high (quotient above, or equal with remainder)
    assign w_mean = w_quot[SAMPLE_W-1:0];
    assign w_anom = (w_mean < r_low) || (w_mean > r_high)
                 || ((w_mean == r_high) && (w_rem != '0));

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = S_SUM;
                    n_cnt   = '0;
                end
            end
            S_SUM: begin
                if (r_cnt == CW'(r_n)) begin
                    n_state = S_DIV;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + CW'(1);
                end
            end
            S_DIV: begin
                if (r_cnt == CW'(SW - 1)) begin
                    n_state = S_LOAD;
                end else begin
                    n_cnt = r_cnt + CW'(1);
                end
            end
            S_LOAD: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_wp        <= '0;
            r_filled    <= 1'b0;
            r_n         <= NW'(1);
            r_low       <= LOW_RESET;
            r_high      <= HIGH_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (w_in_acc) begin
                r_wp     <= w_wrap ? '0 : r_wp + IW'(1);
                r_filled <= r_filled || w_wrap;
                r_n      <= r_filled ? NW'(WINDOW) : NW'(r_wp) + NW'(1);
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_LOW:  r_low  <= i_cfg_data;
                    CFG_HIGH: r_high <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_stamp <= i_in.stamp;
        end
        if (w_load) begin
            r_out_mean  <= w_mean;
            r_out_anom  <= w_anom;
            r_out_stamp <= r_stamp;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.mean      = r_out_mean;
    assign o_out.anomaly   = r_out_anom;
    assign o_out.stamp_out = r_out_stamp;

    `WAVRC_ASSERT_NEXT(a_acc_starts_sum, i_clk, i_rst_n, w_in_acc, r_state == S_SUM,
        "accepted transaction did not start the sum")
    `WAVRC_ASSERT_IMM(a_count_range, i_clk, i_rst_n, r_state != S_IDLE,
        (r_n != '0) && (r_n <= NW'(WINDOW)), "entry count out of range")
    `WAVRC_ASSERT_IMM(a_sum_index, i_clk, i_rst_n, r_state == S_SUM, r_cnt <= CW'(r_n),
        "sum index beyond valid entries")
    `WAVRC_ASSERT_IMM(a_wp_range, i_clk, i_rst_n, 1'b1, r_wp <= IW'(WINDOW - 1),
        "write pointer beyond window")

endmodule

FILE: rtl/core/wavrc_window.sv
// Generic RAM: one write port, one registered read port
module wavrc_window
    import wavrc_pkg::*;
#(
    parameter int WIDTH = SAMPLE_W,
    parameter int DEPTH = WINDOW_DEF,
    parameter int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [IW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [IW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    // Entries are always written before they are summed, so no reset
    logic [WIDTH-1:0] r_store [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_store[i_waddr] <= i_wdata;
        end
        r_rdata <= r_store[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/wavrc_arith.sv
// Shared adder: accumulates the window sum, then runs a restoring divide by n
module wavrc_arith
    import wavrc_pkg::*;
#(
    parameter int NW = 3,
    parameter int SW = 19
) (
    input  logic          i_clk,
    input  t_arith_ctl    i_ctl,
    input  logic [NW-1:0] i_divisor,
    output logic [SW-1:0] o_quot,
    output logic [NW-1:0] o_rem
);

    localparam int AW = SW + 1;

    logic [SW-1:0] r_acc;
    logic [NW-1:0] r_rem;
    logic [NW:0]   w_trial;
    logic [AW-1:0] w_a;
    logic [AW-1:0] w_b;
    logic          w_cin;
    logic [AW:0]   w_sum;
    logic          w_ge;

    // Partial remainder with the next dividend bit shifted in
    assign w_trial = {r_rem, r_acc[SW-1]};

    always_comb begin
        if (i_ctl.op == OP_DIV) begin
            w_a   = AW'(w_trial);
            w_b   = ~AW'(i_divisor);
            w_cin = 1'b1;
        end else begin
            w_a   = {1'b0, r_acc};
            w_b   = AW'(i_ctl.data);
            w_cin = 1'b0;
        end
    end

    assign w_sum = {1'b0, w_a} + {1'b0, w_b} + (AW + 1)'(w_cin);
    // Carry out of the subtract: trial >= divisor
    assign w_ge  = w_sum[AW];

    // Dividend register shifts left and collects quotient bits
    always_ff @(posedge i_clk) begin
        unique case (i_ctl.op)
            OP_CLR: begin
                r_acc <= '0;
                r_rem <= '0;
            end
            OP_ACC: begin
                r_acc <= w_sum[SW-1:0];
            end
            OP_DIV: begin
                r_acc <= {r_acc[SW-2:0], w_ge};
                r_rem <= w_ge ? w_sum[NW-1:0] : w_trial[NW-1:0];
            end
            OP_HOLD: begin
            end
        endcase
    end

    assign o_quot = r_acc;
    assign o_rem  = r_rem;

endmodule
